### rtl/core/escaped_frame_encoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the escaped frame encoder
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_ENCODER_MACROS_SVH
`define ESCAPED_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define EFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("escaped_frame_encoder: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define EFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("escaped_frame_encoder: next-cycle check failed");

`endif

### rtl/core/efe_pkg.sv
// ---------------------------------------------------------------------------
// efe_pkg
// Constants, slot codes and helpers of the escaped frame encoder.
// ---------------------------------------------------------------------------
package efe_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NSlots = 8;
  localparam int unsigned SlotW  = $clog2(NSlots);

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [NSlots-1:0] slot_mask_t;
  typedef logic [SlotW-1:0]  slot_t;

  localparam byte_t HDR_BYTE = 8'hAA;
  localparam byte_t ESC_BYTE = 8'hA5;
  localparam byte_t TRL_BYTE = 8'h55;

  // Fixed slot order of the bytes one input transfer can cause
  localparam slot_t SLOT_HDR0 = 3'd0;
  localparam slot_t SLOT_HDR1 = 3'd1;
  localparam slot_t SLOT_ESCD = 3'd2;
  localparam slot_t SLOT_DATA = 3'd3;
  localparam slot_t SLOT_ESCS = 3'd4;
  localparam slot_t SLOT_SUM  = 3'd5;
  localparam slot_t SLOT_TRL0 = 3'd6;
  localparam slot_t SLOT_TRL1 = 3'd7;

  function automatic logic needs_escape(byte_t b);
    return (b == ESC_BYTE) || (b == HDR_BYTE) || (b == TRL_BYTE);
  endfunction

endpackage

### rtl/core/escaped_frame_encoder.sv
// ---------------------------------------------------------------------------
// escaped_frame_encoder
// Byte-stuffed frame encoder with header, trailer and 8-bit additive checksum.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one payload byte per transfer in tdata, tlast on the final
//   byte of a frame. Master stream: one encoded byte per transfer in tdata,
//   tlast on the final byte caused by one input transfer, tuser on the final
//   trailer byte of the frame.
//   The first byte of a frame is preceded by 0xAA 0xAA, any byte equal to
//   0xA5, 0xAA or 0x55 by the escape 0xA5; the frame closes with the escaped
//   checksum and 0x55 0x55.
//   The first output byte passes the input register, then the slot register,
//   before it is presented. An input transfer then occupies the output with
//   1 to 8 bytes, one transfer per byte it causes, all held in the slot
//   register, so payload without escapes runs at one byte per cycle while
//   the output is not stalled, and each escaped payload byte is sent as two
//   output bytes.
//   The input register takes the next byte while the output is busy or
//   stalled; when both registers are full, s_axis_tready_o drops.
//   Reset empties both registers and closes any open frame.
// ---------------------------------------------------------------------------
module escaped_frame_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  efe_pkg::byte_t     s_axis_tdata_i,   // [7:0] data_byte
  input  logic               s_axis_tlast_i,   // last_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output efe_pkg::byte_t     m_axis_tdata_o,   // [7:0] out_byte
  output logic               m_axis_tlast_o,   // end_of_burst
  output logic               m_axis_tuser_o    // [0] end_of_frame
);
  import efe_pkg::*;

  // Input register
  logic  in_valid_q, in_valid_d;
  byte_t in_data_q;
  logic  in_last_q;

  // Frame state
  logic  in_frame_q, in_frame_d;
  byte_t sum_q, sum_d;

  // Slot register: remaining slots of the current item
  slot_mask_t rem_q, rem_d;
  byte_t      out_data_q;
  byte_t      out_sum_q;

  logic       in_take, load, emit_take, emit_done, emit_free, single;
  slot_mask_t low_bit, load_mask;
  slot_t      cur_slot;
  byte_t      base_sum, new_sum, cur_byte;

  // Lowest pending slot
  assign low_bit = rem_q & (~rem_q + slot_mask_t'(1));
  assign single  = ((rem_q & (rem_q - slot_mask_t'(1))) == '0);

  always_comb begin
    cur_slot = SLOT_HDR0;
    for (int i = 0; i < NSlots; i++) begin
      if (low_bit[i]) begin
        cur_slot = slot_t'(i);
      end
    end
  end

  always_comb begin
    case (cur_slot)
      SLOT_HDR0, SLOT_HDR1: cur_byte = HDR_BYTE;
      SLOT_ESCD, SLOT_ESCS: cur_byte = ESC_BYTE;
      SLOT_DATA:            cur_byte = out_data_q;
      SLOT_SUM:             cur_byte = out_sum_q;
      SLOT_TRL0, SLOT_TRL1: cur_byte = TRL_BYTE;
      default:              cur_byte = TRL_BYTE;
    endcase
  end

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tdata_o  = cur_byte;
  assign m_axis_tlast_o  = single;
  assign m_axis_tuser_o  = (cur_slot == SLOT_TRL1);

  assign emit_take = m_axis_tvalid_o & m_axis_tready_i;
  assign emit_done = emit_take & single;
  assign emit_free = ~m_axis_tvalid_o | emit_done;
  assign load      = in_valid_q & emit_free;

  assign s_axis_tready_o = ~in_valid_q | load;
  assign in_take         = s_axis_tvalid_i & s_axis_tready_o;

  // Build the slot mask of the held item
  assign base_sum = in_frame_q ? sum_q : '0;
  assign new_sum  = base_sum + in_data_q;

  always_comb begin
    load_mask            = '0;
    load_mask[SLOT_HDR0] = ~in_frame_q;
    load_mask[SLOT_HDR1] = ~in_frame_q;
    load_mask[SLOT_ESCD] = needs_escape(in_data_q);
    load_mask[SLOT_DATA] = 1'b1;
    load_mask[SLOT_ESCS] = in_last_q & needs_escape(new_sum);
    load_mask[SLOT_SUM]  = in_last_q;
    load_mask[SLOT_TRL0] = in_last_q;
    load_mask[SLOT_TRL1] = in_last_q;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    sum_d      = sum_q;
    if (load) begin
      in_frame_d = ~in_last_q;
      sum_d      = in_last_q ? '0 : new_sum;
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = load_mask;
    end else if (emit_take) begin
      rem_d = rem_q & ~low_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_frame_q <= 1'b0;
      sum_q      <= '0;
      rem_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      in_frame_q <= in_frame_d;
      sum_q      <= sum_d;
      rem_q      <= rem_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (load) begin
      out_data_q <= in_data_q;
      out_sum_q  <= new_sum;
    end
  end

endmodule

### rtl/core/efe_checker.sv
// ---------------------------------------------------------------------------
// efe_checker
// Port-level checks of the escaped frame encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "escaped_frame_encoder_macros.svh"

module efe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           m_axis_tvalid_o,
  input logic           m_axis_tready_i,
  input efe_pkg::byte_t m_axis_tdata_o,
  input logic           m_axis_tlast_o,
  input logic           m_axis_tuser_o
);
  import efe_pkg::*;

  logic out_xfer;
  logic out_stall;
  logic eof_out;
  logic hdr_due;
  logic expect_hdr_q;

  assign out_xfer  = m_axis_tvalid_o & m_axis_tready_i;
  assign out_stall = m_axis_tvalid_o & ~m_axis_tready_i;
  assign eof_out   = m_axis_tvalid_o & m_axis_tuser_o;
  assign hdr_due   = m_axis_tvalid_o & expect_hdr_q;

  // Track frame boundaries: the next output after frame end must be a header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
    end else if (out_xfer) begin
      expect_hdr_q <= m_axis_tuser_o;
    end
  end

  `EFE_ASSERT_IMP(a_eof_ends_burst, clk_i, rst_ni, eof_out, m_axis_tlast_o)
  `EFE_ASSERT_IMP(a_eof_is_trailer, clk_i, rst_ni, eof_out, m_axis_tdata_o == TRL_BYTE)
  `EFE_ASSERT_IMP(a_frame_opens_hdr, clk_i, rst_ni, hdr_due, m_axis_tdata_o == HDR_BYTE && !m_axis_tlast_o)
  `EFE_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind escaped_frame_encoder efe_checker u_efe_checker (.*);

### verif/efe_tb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efe_tb_pkg
// Scoreboard of the escaped frame encoder testbench: builds the encoded byte
// stream from every accepted payload transfer and checks each output transfer.
// ---------------------------------------------------------------------------
package efe_tb_pkg;

  import efe_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  burst_end;
    logic  frame_end;
  } coded_byte_t;

  class frame_scoreboard;
    coded_byte_t expected_q[$];
    bit          frame_open;
    byte_t       frame_sum;
    int unsigned mismatches;

    function new();
      frame_open = 1'b0;
      frame_sum  = '0;
      mismatches = 0;
    endfunction

    function bit is_reserved(byte_t b);
      return (b == HDR_BYTE) || (b == ESC_BYTE) || (b == TRL_BYTE);
    endfunction

    function void push_byte(byte_t b, bit eof);
      coded_byte_t c;
      c.data      = b;
      c.burst_end = 1'b0;
      c.frame_end = eof;
      expected_q.push_back(c);
    endfunction

    function void push_stuffed(byte_t b);
      if (is_reserved(b)) push_byte(ESC_BYTE, 1'b0);
      push_byte(b, 1'b0);
    endfunction

    // Expand one accepted payload byte into the bytes it causes
    function void note_input(byte_t d, bit l);
      coded_byte_t tail;
      if (!frame_open) begin
        push_byte(HDR_BYTE, 1'b0);
        push_byte(HDR_BYTE, 1'b0);
        frame_open = 1'b1;
        frame_sum  = '0;
      end
      push_stuffed(d);
      frame_sum = frame_sum + d;
      if (l) begin
        push_stuffed(frame_sum);
        push_byte(TRL_BYTE, 1'b0);
        push_byte(TRL_BYTE, 1'b1);
        frame_open = 1'b0;
        frame_sum  = '0;
      end
      // mark the final byte of this transfer's burst
      tail = expected_q.pop_back();
      tail.burst_end = 1'b1;
      expected_q.push_back(tail);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("ERROR: %s", msg);
    endtask

    task check_output(byte_t b, logic eob, logic eof);
      coded_byte_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("output byte %02h with nothing expected", b));
        return;
      end
      want = expected_q.pop_front();
      if (b !== want.data)
        report($sformatf("out_byte %02h, expected %02h", b, want.data));
      if (eob !== want.burst_end)
        report($sformatf("end_of_burst %b, expected %b (byte %02h)", eob, want.burst_end,
                         want.data));
      if (eof !== want.frame_end)
        report($sformatf("end_of_frame %b, expected %b (byte %02h)", eof, want.frame_end,
                         want.data));
    endtask
  endclass

endpackage

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives payload frames into the escaped frame encoder with bursty input and
// a stalling output, and checks every encoded byte against the scoreboard.
// ---------------------------------------------------------------------------
module testbench;

  import efe_pkg::*;
  import efe_tb_pkg::*;

  localparam int unsigned RandomItems = 450;

  logic  clk_i;
  logic  rst_ni;
  logic  s_axis_tvalid;
  logic  s_axis_tready;
  byte_t s_axis_tdata;
  logic  s_axis_tlast;
  logic  m_axis_tvalid;
  logic  m_axis_tready;
  byte_t m_axis_tdata;
  logic  m_axis_tlast;
  logic  m_axis_tuser;

  frame_scoreboard frame_sb;
  int unsigned     items_sent;
  int unsigned     burst_left;
  bit              stall_done;

  escaped_frame_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one payload byte; called at a falling edge, returns at a falling edge
  task send_item(byte_t d, bit l);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    frame_sb.note_input(d, l);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 9))
      0:       return HDR_BYTE;
      1:       return ESC_BYTE;
      2:       return TRL_BYTE;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Random frame; sometimes the last byte steers the checksum onto a reserved value
  task send_frame(int unsigned len);
    byte_t sum;
    byte_t d;
    sum = '0;
    for (int unsigned i = 0; i < len; i++) begin
      d = pick_byte();
      if (i == len - 1 && $urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0:       d = HDR_BYTE - sum;
          1:       d = ESC_BYTE - sum;
          default: d = TRL_BYTE - sum;
        endcase
      end
      sum = sum + d;
      send_item(d, i == len - 1);
    end
  endtask

  // Output side: stall pattern of its own, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned span;
    stall_done    = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk_i);
        if (!stall_done && items_sent >= 120) begin
          stall_done = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (300) @(negedge clk_i);
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      frame_sb.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    frame_sb      = new();
    items_sent    = 0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single-byte frames at the extremes and on each reserved value
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(HDR_BYTE, 1'b1);
    send_item(ESC_BYTE, 1'b1);
    send_item(TRL_BYTE, 1'b1);
    // checksum lands on each reserved value
    send_item(8'h50, 1'b0);
    send_item(8'h05, 1'b1);
    send_item(8'hA0, 1'b0);
    send_item(8'h05, 1'b1);
    send_item(8'h2A, 1'b0);
    send_item(8'h80, 1'b1);
    // wrapping sum, reserved bytes mid-frame
    send_item(8'h01, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h02, 1'b1);
    send_item(ESC_BYTE, 1'b0);
    send_item(HDR_BYTE, 1'b0);
    send_item(TRL_BYTE, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b1);

    while (items_sent < RandomItems + 20)
      send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10));

    s_axis_tvalid <= 1'b0;
    while (frame_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (frame_sb.mismatches == 0 && frame_sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
